// ===== design/tdrd_pkg.sv =====
// Shared types, event codes and tool id lookup for the tablet report decoder.
`timescale 1ns / 1ps

package tdrd_pkg;

	// event kinds
	localparam logic [1:0] EV_KEY = 2'd0;
	localparam logic [1:0] EV_ABS = 2'd1;
	localparam logic [1:0] EV_REL = 2'd2;
	localparam logic [1:0] EV_SER = 2'd3;

	// key codes (tool kinds share the low codes)
	localparam logic [3:0] KEY_PEN      = 4'd1;
	localparam logic [3:0] KEY_RUBBER   = 4'd2;
	localparam logic [3:0] KEY_BRUSH    = 4'd3;
	localparam logic [3:0] KEY_PENCIL   = 4'd4;
	localparam logic [3:0] KEY_AIRBRUSH = 4'd5;
	localparam logic [3:0] KEY_MOUSE    = 4'd6;
	localparam logic [3:0] KEY_LENS     = 4'd7;
	localparam logic [3:0] KEY_TOUCH    = 4'd8;
	localparam logic [3:0] KEY_STYLUS   = 4'd9;
	localparam logic [3:0] KEY_STYLUS2  = 4'd10;
	localparam logic [3:0] KEY_LEFT     = 4'd11;
	localparam logic [3:0] KEY_RIGHT    = 4'd12;
	localparam logic [3:0] KEY_MIDDLE   = 4'd13;
	localparam logic [3:0] KEY_SIDE     = 4'd14;
	localparam logic [3:0] KEY_EXTRA    = 4'd15;

	// absolute axes
	localparam logic [3:0] AX_X     = 4'd0;
	localparam logic [3:0] AX_Y     = 4'd1;
	localparam logic [3:0] AX_DIST  = 4'd2;
	localparam logic [3:0] AX_PRESS = 4'd3;
	localparam logic [3:0] AX_TILTX = 4'd4;
	localparam logic [3:0] AX_TILTY = 4'd5;
	localparam logic [3:0] AX_WHEEL = 4'd6;
	localparam logic [3:0] AX_RZ    = 4'd7;
	localparam logic [3:0] AX_THROT = 4'd8;

	localparam logic [2:0] KIND_NONE = 3'd0;

	// report classes
	localparam logic [3:0] CLS_ENTER = 4'd0;
	localparam logic [3:0] CLS_EXIT  = 4'd1;
	localparam logic [3:0] CLS_PEN   = 4'd2;
	localparam logic [3:0] CLS_AIR   = 4'd3;
	localparam logic [3:0] CLS_ROT   = 4'd4;
	localparam logic [3:0] CLS_M4D   = 4'd5;
	localparam logic [3:0] CLS_M2D   = 4'd6;
	localparam logic [3:0] CLS_LENS  = 4'd7;
	localparam logic [3:0] CLS_NONE  = 4'd8;

	localparam logic [9:0] THRESH_RESET = 10'd10;

	typedef struct packed {
		logic [3:0]  cls;
		logic [2:0]  kind;
		logic [31:0] serial;
		logic        touch;
		logic [7:0]  status;
		logic [7:0]  b2;
		logic [7:0]  b3;
		logic [7:0]  b4;
		logic [7:0]  b5;
		logic [7:0]  b6;
		logic [7:0]  b7;
		logic [7:0]  b8;
		logic [7:0]  b9;
	} entry_t;

	function automatic logic [2:0] tool_kind_of_id(input logic [11:0] id);
		logic [3:0] k;
		unique case (id)
			12'h812, 12'h012:                           k = KEY_PENCIL;
			12'h822, 12'h842, 12'h852, 12'h022:         k = KEY_PEN;
			12'h832, 12'h032:                           k = KEY_BRUSH;
			12'h007, 12'h09c, 12'h094:                  k = KEY_MOUSE;
			12'h096:                                    k = KEY_LENS;
			12'h82a, 12'h85a, 12'h91a, 12'hd1a, 12'h0fa: k = KEY_RUBBER;
			12'hd12, 12'h912, 12'h112:                  k = KEY_AIRBRUSH;
			default:                                    k = KEY_PEN;
		endcase
		return k[2:0];
	endfunction

endpackage

// ===== design/tdrd_front.sv =====
// Front end: takes reports, keeps slot state, classifies and queues a work entry.
`timescale 1ns / 1ps

module tdrd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        status_byte,
	input  logic [7:0]        byte2,
	input  logic [7:0]        byte3,
	input  logic [7:0]        byte4,
	input  logic [7:0]        byte5,
	input  logic [7:0]        byte6,
	input  logic [7:0]        byte7,
	input  logic [7:0]        byte8,
	input  logic [7:0]        byte9,
	input  logic              cfg_wr_en,
	input  logic [9:0]        cfg_wr_data,
	output logic              push_valid,
	input  logic              push_ready,
	output tdrd_pkg::entry_t  push_data
);
	import tdrd_pkg::*;

	localparam logic [7:0] M_ENTER = 8'hfc, P_ENTER = 8'hc0;
	localparam logic [7:0] M_EXIT  = 8'hfe, P_EXIT  = 8'h80;
	localparam logic [7:0] M_PEN   = 8'hb8, P_PEN   = 8'ha0;
	localparam logic [7:0] M_AIR   = 8'hbc, P_AIR   = 8'hb4;
	localparam logic [7:0] M_MSA   = 8'hbc, P_MSA   = 8'ha8;
	localparam logic [7:0] M_MSB   = 8'hbe, P_MSB   = 8'hb0;

	logic [9:0]  thresh_q;
	logic [2:0]  kind_q [2];
	logic [31:0] serial_q [2];

	logic        slot;
	logic        is_enter;
	logic        accept;
	logic [9:0]  v10;
	logic [31:0] new_serial;
	logic [2:0]  new_kind;
	logic [2:0]  cur_kind;
	logic [3:0]  cls;

	assign slot       = status_byte[0];
	assign is_enter   = (status_byte & M_ENTER) == P_ENTER;
	assign accept     = in_valid && push_ready;
	assign v10        = {byte6, byte7[7:6]};
	assign new_serial = {byte3[3:0], byte4, byte5, byte6, byte7[7:4]};
	assign new_kind   = tool_kind_of_id({byte2, byte3[7:4]});
	assign cur_kind   = is_enter ? new_kind : kind_q[slot];

	always_comb begin
		if (is_enter)
			cls = CLS_ENTER;
		else if ((status_byte & M_EXIT) == P_EXIT)
			cls = CLS_EXIT;
		else if ((status_byte & M_PEN) == P_PEN)
			cls = CLS_PEN;
		else if ((status_byte & M_AIR) == P_AIR)
			cls = CLS_AIR;
		else if ((status_byte & M_MSA) == P_MSA || (status_byte & M_MSB) == P_MSB) begin
			if (status_byte[1])
				cls = CLS_ROT;
			else if (!status_byte[4])
				cls = CLS_M4D;
			else if (cur_kind == KEY_MOUSE[2:0])
				cls = CLS_M2D;
			else
				cls = CLS_LENS;
		end else
			cls = CLS_NONE;
	end

	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	always_comb begin
		push_data        = '0;
		push_data.cls    = cls;
		push_data.kind   = cur_kind;
		push_data.serial = is_enter ? new_serial : serial_q[slot];
		push_data.touch  = v10 > thresh_q;
		push_data.status = status_byte;
		push_data.b2     = byte2;
		push_data.b3     = byte3;
		push_data.b4     = byte4;
		push_data.b5     = byte5;
		push_data.b6     = byte6;
		push_data.b7     = byte7;
		push_data.b8     = byte8;
		push_data.b9     = byte9;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q    <= THRESH_RESET;
			kind_q[0]   <= KIND_NONE;
			kind_q[1]   <= KIND_NONE;
			serial_q[0] <= '0;
			serial_q[1] <= '0;
		end else begin
			if (cfg_wr_en)
				thresh_q <= cfg_wr_data;
			if (accept && is_enter) begin
				kind_q[slot]   <= new_kind;
				serial_q[slot] <= new_serial;
			end
		end
	end

endmodule

// ===== design/tdrd_queue.sv =====
// Small FIFO of work entries between front and back end.
`timescale 1ns / 1ps

module tdrd_queue #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  tdrd_pkg::entry_t  push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output tdrd_pkg::entry_t  pop_data
);
	import tdrd_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== design/tdrd_back.sv =====
// Back end: steps through one entry, one event per cycle while out_ready allows, into the output register.
`timescale 1ns / 1ps

module tdrd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               entry_valid,
	output logic               entry_pop,
	input  tdrd_pkg::entry_t   entry,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         event_kind,
	output logic [3:0]         event_code,
	output logic signed [32:0] event_value,
	output logic               last_event
);
	import tdrd_pkg::*;

	logic [3:0]  step_q;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [3:0]  code_q;
	logic [32:0] value_q;
	logic        last_q;

	logic [3:0]  cnt;
	logic [3:0]  j;
	logic        fire;
	logic [1:0]  ev_kind;
	logic [3:0]  ev_code;
	logic [32:0] ev_value;
	logic        ev_last;
	logic [9:0]  v10;
	logic [6:0]  tx;
	logic [6:0]  ty;
	logic [32:0] rot;
	logic [32:0] thr;
	logic [32:0] rel;

	// events before the tool key, per class
	always_comb begin
		unique case (entry.cls)
			CLS_PEN:  cnt = 4'd9;
			CLS_AIR:  cnt = 4'd6;
			CLS_ROT:  cnt = 4'd4;
			CLS_M4D:  cnt = 4'd9;
			CLS_M2D:  cnt = 4'd7;
			CLS_LENS: cnt = 4'd8;
			CLS_NONE: cnt = 4'd3;
			default:  cnt = 4'd0;
		endcase
	end

	assign j   = step_q - 4'd3;
	assign v10 = {entry.b6, entry.b7[7:6]};
	assign tx  = {entry.b7[5:0], entry.b8[7]};
	assign ty  = entry.b8[6:0];
	// rotation: negative side is -r-1, i.e. the complement
	assign rot = entry.b7[5] ? {22'd0, entry.b6, entry.b7[7:5]}
		: ~{22'd0, entry.b6, entry.b7[7:5]};
	assign thr = entry.b8[3] ? (33'd0 - {23'd0, v10}) : {23'd0, v10};
	assign rel = {32'd0, entry.b8[1]} - {32'd0, entry.b8[0]};

	always_comb begin
		ev_kind  = EV_SER;
		ev_code  = '0;
		ev_value = {1'b0, entry.serial};
		ev_last  = 1'b1;
		if (step_q < cnt) begin
			ev_last = 1'b0;
			ev_kind = EV_ABS;
			case (step_q)
				4'd0: begin ev_code = AX_X; ev_value = {17'd0, entry.b2, entry.b3}; end
				4'd1: begin ev_code = AX_Y; ev_value = {17'd0, entry.b4, entry.b5}; end
				4'd2: begin ev_code = AX_DIST; ev_value = {25'd0, entry.b9}; end
				default: begin
					unique case (entry.cls)
						CLS_PEN: begin
							case (j)
								4'd0: begin ev_code = AX_PRESS; ev_value = {23'd0, v10}; end
								4'd1: begin ev_code = AX_TILTX; ev_value = {26'd0, tx}; end
								4'd2: begin ev_code = AX_TILTY; ev_value = {26'd0, ty}; end
								4'd3: begin
									ev_kind = EV_KEY; ev_code = KEY_STYLUS;
									ev_value = {32'd0, entry.status[1]};
								end
								4'd4: begin
									ev_kind = EV_KEY; ev_code = KEY_STYLUS2;
									ev_value = {32'd0, entry.status[2]};
								end
								default: begin
									ev_kind = EV_KEY; ev_code = KEY_TOUCH;
									ev_value = {32'd0, entry.touch};
								end
							endcase
						end
						CLS_AIR: begin
							case (j)
								4'd0: begin ev_code = AX_WHEEL; ev_value = {23'd0, v10}; end
								4'd1: begin ev_code = AX_TILTX; ev_value = {26'd0, tx}; end
								default: begin ev_code = AX_TILTY; ev_value = {26'd0, ty}; end
							endcase
						end
						CLS_ROT: begin
							ev_code  = AX_RZ;
							ev_value = rot;
						end
						CLS_M4D: begin
							ev_kind = EV_KEY;
							case (j)
								4'd0: begin ev_code = KEY_LEFT; ev_value = {32'd0, entry.b8[0]}; end
								4'd1: begin ev_code = KEY_MIDDLE; ev_value = {32'd0, entry.b8[1]}; end
								4'd2: begin ev_code = KEY_RIGHT; ev_value = {32'd0, entry.b8[2]}; end
								4'd3: begin ev_code = KEY_SIDE; ev_value = {32'd0, entry.b8[5]}; end
								4'd4: begin ev_code = KEY_EXTRA; ev_value = {32'd0, entry.b8[4]}; end
								default: begin
									ev_kind = EV_ABS; ev_code = AX_THROT; ev_value = thr;
								end
							endcase
						end
						CLS_M2D: begin
							ev_kind = EV_KEY;
							case (j)
								4'd0: begin ev_code = KEY_LEFT; ev_value = {32'd0, entry.b8[2]}; end
								4'd1: begin ev_code = KEY_MIDDLE; ev_value = {32'd0, entry.b8[3]}; end
								4'd2: begin ev_code = KEY_RIGHT; ev_value = {32'd0, entry.b8[4]}; end
								default: begin
									ev_kind = EV_REL; ev_code = '0; ev_value = rel;
								end
							endcase
						end
						default: begin
							// lens cursor
							ev_kind = EV_KEY;
							case (j)
								4'd0: begin ev_code = KEY_LEFT; ev_value = {32'd0, entry.b8[0]}; end
								4'd1: begin ev_code = KEY_MIDDLE; ev_value = {32'd0, entry.b8[1]}; end
								4'd2: begin ev_code = KEY_RIGHT; ev_value = {32'd0, entry.b8[2]}; end
								4'd3: begin ev_code = KEY_SIDE; ev_value = {32'd0, entry.b8[4]}; end
								default: begin ev_code = KEY_EXTRA; ev_value = {32'd0, entry.b8[3]}; end
							endcase
						end
					endcase
				end
			endcase
		end else if (step_q == cnt && entry.kind != KIND_NONE) begin
			ev_last  = 1'b0;
			ev_kind  = EV_KEY;
			ev_code  = {1'b0, entry.kind};
			ev_value = {32'd0, entry.cls != CLS_EXIT};
		end
	end

	assign fire      = entry_valid && (!out_valid_q || out_ready);
	assign entry_pop = fire && ev_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				step_q      <= ev_last ? 4'd0 : step_q + 4'd1;
			end else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			kind_q  <= ev_kind;
			code_q  <= ev_code;
			value_q <= ev_value;
			last_q  <= ev_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_kind  = kind_q;
	assign event_code  = code_q;
	assign event_value = signed'(value_q);
	assign last_event  = last_q;

endmodule

// ===== design/tablet_dual_tool_report_decoder_unit.sv =====
// Top level of the dual-slot tablet report decoder.
// channel   | handshake              | payload
// ----------+------------------------+-------------------------------------------
// report in | in_valid / in_ready    | status_byte, byte2 .. byte9
// event out | out_valid / out_ready  | event_kind, event_code, event_value, last_event
// config    | cfg_wr_en              | cfg_wr_data (touch threshold)
// The back end emits one event per cycle while out_ready allows, and a report yields 1 to 11
// events; the front takes one report per cycle while the queue has room.
// Reset empties the queue, clears both slots and sets the touch threshold to 10.
// out_ready low holds the output register; the queue then fills and in_ready drops.
`timescale 1ns / 1ps

module tablet_dual_tool_report_decoder_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         status_byte,
	input  logic [7:0]         byte2,
	input  logic [7:0]         byte3,
	input  logic [7:0]         byte4,
	input  logic [7:0]         byte5,
	input  logic [7:0]         byte6,
	input  logic [7:0]         byte7,
	input  logic [7:0]         byte8,
	input  logic [7:0]         byte9,
	input  logic               cfg_wr_en,
	input  logic [9:0]         cfg_wr_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         event_kind,
	output logic [3:0]         event_code,
	output logic signed [32:0] event_value,
	output logic               last_event
);
	import tdrd_pkg::*;

	logic   push_valid;
	logic   push_ready;
	entry_t push_data;
	logic   q_valid;
	logic   q_pop;
	entry_t q_data;

	tdrd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.status_byte (status_byte),
		.byte2       (byte2),
		.byte3       (byte3),
		.byte4       (byte4),
		.byte5       (byte5),
		.byte6       (byte6),
		.byte7       (byte7),
		.byte8       (byte8),
		.byte9       (byte9),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	tdrd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (q_valid),
		.pop_ready  (q_pop),
		.pop_data   (q_data)
	);

	tdrd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (q_valid),
		.entry_pop   (q_pop),
		.entry       (q_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.event_kind  (event_kind),
		.event_code  (event_code),
		.event_value (event_value),
		.last_event  (last_event)
	);

	// a report closes with its serial and nothing else is marked last
	a_last_is_serial: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_event == (event_kind == EV_SER)))
		else $error("last_event does not match serial event");

	// retiring an entry loads its closing beat
	a_pop_loads_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (out_valid && last_event))
		else $error("entry retired without closing beat");

	// a full queue is never empty
	a_full_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_valid)
		else $error("input stalled with empty queue");

endmodule
